// ----- hdl/gbrs_pkg.sv -----
// ----------------------------------------------------------------------------
// gbrs_pkg
// shared types and constants of the rgb gaussian blur stream block
// ----------------------------------------------------------------------------
`default_nettype none

package gbrs_pkg;

    localparam int RADIUS_DEF     = 1;
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 8192;

    localparam int CH_W        = 8;
    localparam int PIX_W       = 3 * CH_W;
    localparam int WGT_W       = 16;
    localparam int NWGT        = 4;
    localparam int WSEL_W      = 2;
    localparam int ROW_FIELD_W = 13;
    localparam int COL_FIELD_W = 12;
    localparam int IMG_W_W     = 13;
    localparam int IMG_H_W     = 14;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int SAT_MAX     = 255;
    localparam int FRAC_SHIFT  = 2 * WGT_W;
    localparam int S_TDATA_W   = PIX_W;
    localparam int M_TDATA_W   = 56;

    localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = IMG_W_W'(640);
    localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = IMG_H_W'(480);
    localparam logic [WGT_W-1:0]   WEIGHT_0_RST     = WGT_W'(65535);

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_0     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_1     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_2     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_3     = 3'd5;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ISSUE,
        ST_DRAIN,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic              issue;
        logic              first;
        logic [WSEL_W-1:0] wr_sel;
        logic [WSEL_W-1:0] wc_sel;
    } tap_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/gbrs_store.sv -----
// ----------------------------------------------------------------------------
// gbrs_store
// line store: one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module gbrs_store import gbrs_pkg::*; #(
    parameter int DEPTH  = 3 * MAX_WIDTH_DEF,
    parameter int ADDR_W = $clog2(3 * MAX_WIDTH_DEF)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [PIX_W-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [PIX_W-1:0]  rd_data
);

    logic [PIX_W-1:0] mem_array [DEPTH];
    logic [PIX_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hdl/gbrs_mac.sv -----
// ----------------------------------------------------------------------------
// gbrs_mac
// tap weight product, per channel multiply and accumulate
// ----------------------------------------------------------------------------
`default_nettype none

module gbrs_mac import gbrs_pkg::*; #(
    parameter int ACC_W = FRAC_SHIFT + CH_W + 4
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire tap_ctl_t                    tap,
    input  wire logic [NWGT-1:0][WGT_W-1:0]  weight,
    input  wire logic [PIX_W-1:0]            rd_data,
    output logic      [ACC_W-1:0]            acc_red,
    output logic      [ACC_W-1:0]            acc_green,
    output logic      [ACC_W-1:0]            acc_blue,
    output logic                             busy
);

    localparam int K_W    = 2 * WGT_W;
    localparam int PROD_W = K_W + CH_W;

    logic              a_valid_reg, b_valid_reg;
    logic              a_first_reg, b_first_reg;
    logic [K_W-1:0]    k_reg;
    logic [PROD_W-1:0] prod_red_reg, prod_green_reg, prod_blue_reg;
    logic [ACC_W-1:0]  acc_red_reg, acc_green_reg, acc_blue_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= tap.issue;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        a_first_reg    <= tap.first;
        k_reg          <= K_W'(weight[tap.wr_sel]) * K_W'(weight[tap.wc_sel]);
        b_first_reg    <= a_first_reg;
        prod_red_reg   <= PROD_W'(k_reg) * PROD_W'(rd_data[3*CH_W-1:2*CH_W]);
        prod_green_reg <= PROD_W'(k_reg) * PROD_W'(rd_data[2*CH_W-1:CH_W]);
        prod_blue_reg  <= PROD_W'(k_reg) * PROD_W'(rd_data[CH_W-1:0]);
        if (b_valid_reg) begin
            if (b_first_reg) begin
                acc_red_reg   <= ACC_W'(prod_red_reg);
                acc_green_reg <= ACC_W'(prod_green_reg);
                acc_blue_reg  <= ACC_W'(prod_blue_reg);
            end else begin
                acc_red_reg   <= acc_red_reg + ACC_W'(prod_red_reg);
                acc_green_reg <= acc_green_reg + ACC_W'(prod_green_reg);
                acc_blue_reg  <= acc_blue_reg + ACC_W'(prod_blue_reg);
            end
        end
    end

    assign acc_red   = acc_red_reg;
    assign acc_green = acc_green_reg;
    assign acc_blue  = acc_blue_reg;
    assign busy      = a_valid_reg | b_valid_reg;

endmodule

`default_nettype wire

// ----- hdl/gaussian_blur_rgb_stream.sv -----
// ----------------------------------------------------------------------------
// gaussian_blur_rgb_stream
// rgb gaussian blur over a raster frame with replicated borders
// ----------------------------------------------------------------------------
// pixels enter on s_ (tuser 0 = pixel, 1 = flush), blurred pixels leave on m_
// with their row and column; tlast marks the last result of one input
// transfer, m_tuser marks the last pixel of the frame. registers are written
// on the cfg channel; a size write restarts the frame.
// a pixel is written into the line store in its accept cycle, then the check
// state decides whether it releases outputs. each output walks (2R+1)^2 taps
// through the single read port of the line store, one tap a cycle, then the
// drain state waits for the multiply-accumulate to empty and the push state
// loads the output register. s_tready stays low until a pixel's results are
// all loaded. results lag the input by R rows and R columns; flush transfers
// after the frame release the rest, one each.
// reset clears all counters and restores the register defaults; line store
// contents are not cleared, every read hits a pixel of the current frame.
// when the receiver stalls, the result waits in the output register and the
// next result is held back until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_blur_rgb_stream import gbrs_pkg::*; #(
    parameter int RADIUS     = RADIUS_DEF,
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // in_red, in_green, in_blue
    input  wire logic                  s_tuser,   // operation
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_TDATA_W-1:0]  m_tdata,   // out_red, out_green, out_blue,
                                                  // out_row, out_col, zero fill
    output logic                       m_tlast,
    output logic                       m_tuser,   // frame_done
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int NSLOT  = 2 * RADIUS + 1;
    localparam int NTAP   = NSLOT * NSLOT;
    localparam int CW     = $clog2(MAX_WIDTH + 1);
    localparam int CIW    = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT + 1);
    localparam int SLOT_W = $clog2(NSLOT);
    localparam int DW     = SLOT_W + 2;
    localparam int TAP_W  = $clog2(NSLOT);
    localparam int NCNT_W = $clog2(RADIUS + 2);
    localparam int DEPTH  = NSLOT * MAX_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ACC_W  = FRAC_SHIFT + CH_W + $clog2(NTAP);

    state_t state_reg, state_next;

    logic [IMG_W_W-1:0]           image_width_reg, image_width_next;
    logic [IMG_H_W-1:0]           image_height_reg, image_height_next;
    logic [NWGT-1:0][WGT_W-1:0]   weight_reg, weight_next;

    logic [RW-1:0]     in_row_reg, in_row_next;
    logic [CW-1:0]     in_col_reg, in_col_next;
    logic [SLOT_W-1:0] in_slot_reg, in_slot_next;
    logic [RW-1:0]     emit_row_reg, emit_row_next;
    logic [CW-1:0]     emit_col_reg, emit_col_next;
    logic [SLOT_W-1:0] emit_slot_reg, emit_slot_next;
    logic [NCNT_W-1:0] run_cnt_reg, run_cnt_next;
    logic [TAP_W-1:0]  dr_idx_reg, dr_idx_next;
    logic [TAP_W-1:0]  dc_idx_reg, dc_idx_next;
    logic              flush_reg, flush_next;

    logic [RW-1:0] item_row_reg, item_row_next;
    logic [CW-1:0] item_col_reg, item_col_next;
    logic          row_end_reg, row_end_next;

    logic                   out_valid_reg, out_valid_next;
    logic [CH_W-1:0]        out_red_reg, out_red_next;
    logic [CH_W-1:0]        out_green_reg, out_green_next;
    logic [CH_W-1:0]        out_blue_reg, out_blue_next;
    logic [ROW_FIELD_W-1:0] out_row_reg, out_row_next;
    logic [COL_FIELD_W-1:0] out_col_reg, out_col_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_done_reg, out_done_next;

    logic [CW-1:0] eff_w;
    logic [RW-1:0] eff_h;
    logic          in_xfer, cfg_xfer, in_pix_ok, flush_ok, can_load, last_tap;
    logic          done_now, more;
    logic [RW-1:0]     emit_row_adv;
    logic [CW-1:0]     emit_col_adv;
    logic [SLOT_W-1:0] emit_slot_adv;

    logic signed [RW+1:0]   rsum, dfull;
    logic [RW-1:0]          rr;
    logic signed [DW-1:0]   ssum;
    logic [SLOT_W-1:0]      rd_slot;
    logic signed [CW+1:0]   csum;
    logic [CW-1:0]          cc;

    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [PIX_W-1:0]  rd_data;
    tap_ctl_t          tap;
    logic [ACC_W-1:0]  acc_red, acc_green, acc_blue;
    logic              mac_busy;

    function automatic logic [WSEL_W-1:0] wsel(input logic [TAP_W-1:0] idx);
        logic [TAP_W-1:0] mag;
        mag = (idx >= TAP_W'(RADIUS)) ? idx - TAP_W'(RADIUS) : TAP_W'(RADIUS) - idx;
        return WSEL_W'(mag);
    endfunction

    function automatic logic [CH_W-1:0] sat_ch(input logic [ACC_W-1:0] a);
        logic [ACC_W-FRAC_SHIFT-1:0] hi;
        hi = a[ACC_W-1:FRAC_SHIFT];
        return (hi > (ACC_W-FRAC_SHIFT)'(SAT_MAX)) ? CH_W'(SAT_MAX) : hi[CH_W-1:0];
    endfunction

    function automatic logic may_emit(input logic [RW-1:0] er, input logic [CW-1:0] ec,
                                      input logic [NCNT_W-1:0] n);
        logic row_hit, col_hit;
        row_hit = (item_row_reg >= RW'(RADIUS))
                  && (({1'b0, er} + (RW+1)'(RADIUS)) == {1'b0, item_row_reg});
        col_hit = row_end_reg || (({1'b0, ec} + (CW+1)'(RADIUS)) <= {1'b0, item_col_reg});
        return row_hit && col_hit && (n < NCNT_W'(RADIUS + 1));
    endfunction

    // effective frame size
    always_comb begin
        if (image_width_reg == '0) begin
            eff_w = CW'(1);
        end else if (32'(image_width_reg) > 32'(MAX_WIDTH)) begin
            eff_w = CW'(MAX_WIDTH);
        end else begin
            eff_w = CW'(image_width_reg);
        end
        if (image_height_reg == '0) begin
            eff_h = RW'(1);
        end else if (32'(image_height_reg) > 32'(MAX_HEIGHT)) begin
            eff_h = RW'(MAX_HEIGHT);
        end else begin
            eff_h = RW'(image_height_reg);
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign in_pix_ok = (in_row_reg < eff_h) && (in_col_reg < eff_w);
    assign flush_ok  = (in_row_reg >= eff_h) && (emit_row_reg < eff_h);
    assign can_load  = !out_valid_reg || m_tready;
    assign last_tap  = (dr_idx_reg == TAP_W'(2 * RADIUS)) && (dc_idx_reg == TAP_W'(2 * RADIUS));

    // emit position after the current result
    always_comb begin
        done_now      = (emit_row_reg == eff_h - RW'(1)) && (emit_col_reg == eff_w - CW'(1));
        emit_row_adv  = emit_row_reg;
        emit_col_adv  = emit_col_reg + CW'(1);
        emit_slot_adv = emit_slot_reg;
        if (done_now) begin
            emit_row_adv  = '0;
            emit_col_adv  = '0;
            emit_slot_adv = '0;
        end else if (emit_col_reg + CW'(1) >= eff_w) begin
            emit_col_adv  = '0;
            emit_row_adv  = emit_row_reg + RW'(1);
            emit_slot_adv = (emit_slot_reg == SLOT_W'(NSLOT - 1)) ? '0
                            : emit_slot_reg + SLOT_W'(1);
        end
        more = !flush_reg && !done_now
               && may_emit(emit_row_adv, emit_col_adv, run_cnt_reg + NCNT_W'(1));
    end

    // tap address with border replication
    always_comb begin
        rsum = $signed((RW+2)'(emit_row_reg)) + $signed((RW+2)'(dr_idx_reg))
               - $signed((RW+2)'(RADIUS));
        if (rsum < 0) begin
            rr = '0;
        end else if (rsum > $signed((RW+2)'(eff_h)) - 1) begin
            rr = eff_h - RW'(1);
        end else begin
            rr = rsum[RW-1:0];
        end
        dfull = $signed((RW+2)'(rr)) - $signed((RW+2)'(emit_row_reg));
        ssum  = $signed(DW'(emit_slot_reg)) + dfull[DW-1:0];
        if (ssum < 0) begin
            rd_slot = SLOT_W'(ssum + $signed(DW'(NSLOT)));
        end else if (ssum >= $signed(DW'(NSLOT))) begin
            rd_slot = SLOT_W'(ssum - $signed(DW'(NSLOT)));
        end else begin
            rd_slot = SLOT_W'(ssum);
        end
        csum = $signed((CW+2)'(emit_col_reg)) + $signed((CW+2)'(dc_idx_reg))
               - $signed((CW+2)'(RADIUS));
        if (csum < 0) begin
            cc = '0;
        end else if (csum > $signed((CW+2)'(eff_w)) - 1) begin
            cc = eff_w - CW'(1);
        end else begin
            cc = csum[CW-1:0];
        end
    end

    assign rd_addr = ADDR_W'(rd_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(cc[CIW-1:0]);
    assign wr_addr = ADDR_W'(in_slot_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col_reg[CIW-1:0]);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer && s_tuser == OP_PIXEL && in_pix_ok) begin
                    state_next = ST_CHECK;
                end else if (in_xfer && s_tuser == OP_FLUSH && flush_ok) begin
                    state_next = ST_ISSUE;
                end
            end
            ST_CHECK: begin
                state_next = may_emit(emit_row_reg, emit_col_reg, run_cnt_reg) ? ST_ISSUE
                             : ST_IDLE;
            end
            ST_ISSUE: begin
                if (last_tap) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!mac_busy) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (can_load) begin
                    state_next = more ? ST_ISSUE : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        weight_next       = weight_reg;
        in_row_next       = in_row_reg;
        in_col_next       = in_col_reg;
        in_slot_next      = in_slot_reg;
        emit_row_next     = emit_row_reg;
        emit_col_next     = emit_col_reg;
        emit_slot_next    = emit_slot_reg;
        run_cnt_next      = run_cnt_reg;
        dr_idx_next       = dr_idx_reg;
        dc_idx_next       = dc_idx_reg;
        flush_next        = flush_reg;
        item_row_next     = item_row_reg;
        item_col_next     = item_col_reg;
        row_end_next      = row_end_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_red_next      = out_red_reg;
        out_green_next    = out_green_reg;
        out_blue_next     = out_blue_reg;
        out_row_next      = out_row_reg;
        out_col_next      = out_col_reg;
        out_last_next     = out_last_reg;
        out_done_next     = out_done_reg;
        wr_en             = 1'b0;
        rd_en             = 1'b0;
        tap.issue         = 1'b0;
        tap.first         = (dr_idx_reg == '0) && (dc_idx_reg == '0);
        tap.wr_sel        = wsel(dr_idx_reg);
        tap.wc_sel        = wsel(dc_idx_reg);
        case (state_reg)
            ST_IDLE: begin
                dr_idx_next = '0;
                dc_idx_next = '0;
                if (in_xfer && s_tuser == OP_PIXEL && in_pix_ok) begin
                    wr_en         = 1'b1;
                    item_row_next = in_row_reg;
                    item_col_next = in_col_reg;
                    row_end_next  = (in_col_reg == eff_w - CW'(1));
                    run_cnt_next  = '0;
                    flush_next    = 1'b0;
                    if (in_col_reg + CW'(1) >= eff_w) begin
                        in_col_next  = '0;
                        in_row_next  = in_row_reg + RW'(1);
                        in_slot_next = (in_slot_reg == SLOT_W'(NSLOT - 1)) ? '0
                                       : in_slot_reg + SLOT_W'(1);
                    end else begin
                        in_col_next = in_col_reg + CW'(1);
                    end
                end else if (in_xfer && s_tuser == OP_FLUSH && flush_ok) begin
                    flush_next   = 1'b1;
                    run_cnt_next = '0;
                end
            end
            ST_CHECK: begin
                dr_idx_next = '0;
                dc_idx_next = '0;
            end
            ST_ISSUE: begin
                rd_en     = 1'b1;
                tap.issue = 1'b1;
                if (dc_idx_reg == TAP_W'(2 * RADIUS)) begin
                    dc_idx_next = '0;
                    dr_idx_next = dr_idx_reg + TAP_W'(1);
                end else begin
                    dc_idx_next = dc_idx_reg + TAP_W'(1);
                end
            end
            ST_DRAIN: begin
                dr_idx_next = '0;
                dc_idx_next = '0;
            end
            ST_PUSH: begin
                dr_idx_next = '0;
                dc_idx_next = '0;
                if (can_load) begin
                    out_valid_next = 1'b1;
                    out_red_next   = sat_ch(acc_red);
                    out_green_next = sat_ch(acc_green);
                    out_blue_next  = sat_ch(acc_blue);
                    out_row_next   = ROW_FIELD_W'(emit_row_reg);
                    out_col_next   = COL_FIELD_W'(emit_col_reg);
                    out_last_next  = !more;
                    out_done_next  = done_now;
                    emit_row_next  = emit_row_adv;
                    emit_col_next  = emit_col_adv;
                    emit_slot_next = emit_slot_adv;
                    run_cnt_next   = run_cnt_reg + NCNT_W'(1);
                    if (done_now) begin
                        in_row_next  = '0;
                        in_col_next  = '0;
                        in_slot_next = '0;
                    end
                end
            end
            default: begin
                dr_idx_next = '0;
                dc_idx_next = '0;
            end
        endcase
        if (cfg_xfer) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT: begin
                    if (cfg_index == CFG_IMAGE_WIDTH) begin
                        image_width_next = cfg_data[IMG_W_W-1:0];
                    end else begin
                        image_height_next = cfg_data[IMG_H_W-1:0];
                    end
                    in_row_next    = '0;
                    in_col_next    = '0;
                    in_slot_next   = '0;
                    emit_row_next  = '0;
                    emit_col_next  = '0;
                    emit_slot_next = '0;
                end
                CFG_WEIGHT_0, CFG_WEIGHT_1, CFG_WEIGHT_2, CFG_WEIGHT_3: begin
                    weight_next[WSEL_W'(cfg_index - CFG_WEIGHT_0)] = cfg_data[WGT_W-1:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
            weight_reg       <= {{(NWGT-1)*WGT_W{1'b0}}, WEIGHT_0_RST};
            in_row_reg       <= '0;
            in_col_reg       <= '0;
            in_slot_reg      <= '0;
            emit_row_reg     <= '0;
            emit_col_reg     <= '0;
            emit_slot_reg    <= '0;
            run_cnt_reg      <= '0;
            dr_idx_reg       <= '0;
            dc_idx_reg       <= '0;
            flush_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            state_reg        <= state_next;
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
            weight_reg       <= weight_next;
            in_row_reg       <= in_row_next;
            in_col_reg       <= in_col_next;
            in_slot_reg      <= in_slot_next;
            emit_row_reg     <= emit_row_next;
            emit_col_reg     <= emit_col_next;
            emit_slot_reg    <= emit_slot_next;
            run_cnt_reg      <= run_cnt_next;
            dr_idx_reg       <= dr_idx_next;
            dc_idx_reg       <= dc_idx_next;
            flush_reg        <= flush_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_row_reg  <= item_row_next;
        item_col_reg  <= item_col_next;
        row_end_reg   <= row_end_next;
        out_red_reg   <= out_red_next;
        out_green_reg <= out_green_next;
        out_blue_reg  <= out_blue_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_last_reg  <= out_last_next;
        out_done_reg  <= out_done_next;
    end

    gbrs_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({s_tdata[CH_W-1:0], s_tdata[2*CH_W-1:CH_W], s_tdata[3*CH_W-1:2*CH_W]}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    gbrs_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tap       (tap),
        .weight    (weight_reg),
        .rd_data   (rd_data),
        .acc_red   (acc_red),
        .acc_green (acc_green),
        .acc_blue  (acc_blue),
        .busy      (mac_busy)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - 3*CH_W - ROW_FIELD_W - COL_FIELD_W)'(0),
                       out_col_reg, out_row_reg, out_blue_reg, out_green_reg, out_red_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_done_reg;

endmodule

`default_nettype wire

// ----- hdl/gbrs_checker.sv -----
// ----------------------------------------------------------------------------
// gbrs_checker
// port level checks of the blur stream, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module gbrs_checker import gbrs_pkg::*; (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [S_TDATA_W-1:0]  s_tdata,
    input wire logic                  s_tuser,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [M_TDATA_W-1:0]  m_tdata,
    input wire logic                  m_tlast,
    input wire logic                  m_tuser,
    input wire logic                  cfg_valid,
    input wire logic                  cfg_ready,
    input wire logic [CFG_IDX_W-1:0]  cfg_index,
    input wire logic [CFG_DATA_W-1:0] cfg_data
);

    // stalled result transfer holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled result changed");

    // the frame's last pixel closes its run
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end without tlast");

    // nothing follows the frame's last pixel in the next cycle
    a_done_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser |=> !m_tvalid)
        else $error("result right after frame end");

    // no result straight out of reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind gaussian_blur_rgb_stream gbrs_checker u_gbrs_checker (.*);

`default_nettype wire
